// ===== sv/sii_rd_pkg.sv =====
// shared constants and codes for the sii eeprom read sequencer
`timescale 1ns / 1ps

package sii_rd_pkg;

  localparam int unsigned READ_COMMAND_CODE_DEFAULT = 256;

  // input modes
  localparam logic [1:0] MODE_START    = 2'd0;
  localparam logic [1:0] MODE_COMPLETE = 2'd1;
  localparam logic [1:0] MODE_CANCEL   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_BASE_WORD        = 3'd0;
  localparam logic [2:0] CFG_PAIR_COUNT       = 3'd1;
  localparam logic [2:0] CFG_SLAVE_POSITION   = 3'd2;
  localparam logic [2:0] CFG_BUSY_MASK        = 3'd3;
  localparam logic [2:0] CFG_ERROR_MASK       = 3'd4;
  localparam logic [2:0] CFG_NACK_MASK        = 3'd5;
  localparam logic [2:0] CFG_BUSY_POLL_LIMIT  = 3'd6;
  localparam logic [2:0] CFG_NACK_RETRY_LIMIT = 3'd7;

  // configuration reset values
  localparam logic [15:0] BUSY_MASK_RESET        = 16'h8000;
  localparam logic [15:0] ERROR_MASK_RESET       = 16'h7800;
  localparam logic [15:0] NACK_MASK_RESET        = 16'h2000;
  localparam logic [15:0] BUSY_POLL_LIMIT_RESET  = 16'd1000;
  localparam logic [7:0]  NACK_RETRY_LIMIT_RESET = 8'd3;

  // register window selects
  localparam logic [1:0] REG_ADDRESS = 2'd0;
  localparam logic [1:0] REG_CONTROL = 2'd1;
  localparam logic [1:0] REG_STATUS  = 2'd2;
  localparam logic [1:0] REG_DATA    = 2'd3;

  // sequence status codes
  localparam logic [1:0] STATUS_BUSY   = 2'd0;
  localparam logic [1:0] STATUS_DONE   = 2'd1;
  localparam logic [1:0] STATUS_FAILED = 2'd2;

  localparam logic [15:0] WORD_ALIGN_MASK = 16'hFFFE;

endpackage

// ===== sv/sii_eeprom_read_sequencer_unit.sv =====
// top level of the sii eeprom read sequencer
`timescale 1ns / 1ps

// Reads a run of 32-bit word pairs from one slave's SII EEPROM through its
// register window: address write, read command write, status polls until not
// busy, then a 4-byte data read. Every input beat (start, access completion or
// cancel) gives exactly one result beat naming the next register access, any
// word pair to cache and the sequence status. The state update and result are
// worked out in the cycle of acceptance and held in an output register, so a
// new beat is taken every cycle while the output is free or being taken.
// Configuration registers may only be written while idle.
module sii_eeprom_read_sequencer_unit #(
  parameter logic [15:0] READ_COMMAND_CODE = 16'(sii_rd_pkg::READ_COMMAND_CODE_DEFAULT)
) (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic        access_ok,
  input  logic [7:0]  reply_length,
  input  logic [31:0] reply_data,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        request_valid,
  output logic        request_is_write,
  output logic [1:0]  request_register,
  output logic [15:0] request_payload,
  output logic [2:0]  request_bytes,
  output logic [15:0] request_station,
  output logic        cache_valid,
  output logic [15:0] cache_word_address,
  output logic [31:0] cache_word_pair,
  output logic [1:0]  sequence_status
);

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CTL  = 3'd2;
  localparam logic [2:0] PH_POLL = 3'd3;
  localparam logic [2:0] PH_DATA = 3'd4;
  localparam logic [2:0] PH_DONE = 3'd5;
  localparam logic [2:0] PH_FAIL = 3'd6;

  logic [15:0] base_word;
  logic [15:0] pair_count;
  logic [15:0] slave_position;
  logic [15:0] busy_mask;
  logic [15:0] error_mask;
  logic [15:0] nack_mask;
  logic [15:0] busy_poll_limit;
  logic [7:0]  nack_retry_limit;

  logic [2:0]  phase, phase_next;
  logic [15:0] word_address, word_address_next;
  logic [15:0] pairs_done, pairs_done_next;
  logic [7:0]  nack_retries, nack_retries_next;
  logic [15:0] busy_polls, busy_polls_next;

  logic        cache_hit;
  logic [15:0] poll_status;
  logic [15:0] busy_polls_inc;
  logic [7:0]  nack_retries_inc;
  logic [15:0] pairs_done_inc;
  logic        accept;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      base_word        <= '0;
      pair_count       <= '0;
      slave_position   <= '0;
      busy_mask        <= sii_rd_pkg::BUSY_MASK_RESET;
      error_mask       <= sii_rd_pkg::ERROR_MASK_RESET;
      nack_mask        <= sii_rd_pkg::NACK_MASK_RESET;
      busy_poll_limit  <= sii_rd_pkg::BUSY_POLL_LIMIT_RESET;
      nack_retry_limit <= sii_rd_pkg::NACK_RETRY_LIMIT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        sii_rd_pkg::CFG_BASE_WORD:        base_word        <= cfg_data;
        sii_rd_pkg::CFG_PAIR_COUNT:       pair_count       <= cfg_data;
        sii_rd_pkg::CFG_SLAVE_POSITION:   slave_position   <= cfg_data;
        sii_rd_pkg::CFG_BUSY_MASK:        busy_mask        <= cfg_data;
        sii_rd_pkg::CFG_ERROR_MASK:       error_mask       <= cfg_data;
        sii_rd_pkg::CFG_NACK_MASK:        nack_mask        <= cfg_data;
        sii_rd_pkg::CFG_BUSY_POLL_LIMIT:  busy_poll_limit  <= cfg_data;
        sii_rd_pkg::CFG_NACK_RETRY_LIMIT: nack_retry_limit <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  assign poll_status      = reply_data[15:0];
  assign busy_polls_inc   = busy_polls + 16'd1;
  assign nack_retries_inc = nack_retries + 8'd1;
  assign pairs_done_inc   = pairs_done + 16'd1;

  // sequencer step for one beat
  always_comb begin
    phase_next        = phase;
    word_address_next = word_address;
    pairs_done_next   = pairs_done;
    nack_retries_next = nack_retries;
    busy_polls_next   = busy_polls;
    cache_hit         = 1'b0;
    unique case (mode)
      sii_rd_pkg::MODE_START: begin
        word_address_next = base_word & sii_rd_pkg::WORD_ALIGN_MASK;
        pairs_done_next   = '0;
        nack_retries_next = '0;
        busy_polls_next   = '0;
        phase_next        = (pair_count != 16'd0) ? PH_ADDR : PH_DONE;
      end
      sii_rd_pkg::MODE_COMPLETE: begin
        if (!access_ok) begin
          phase_next = PH_FAIL;
        end else begin
          unique case (phase)
            PH_ADDR: phase_next = PH_CTL;
            PH_CTL: begin
              busy_polls_next = '0;
              phase_next      = PH_POLL;
            end
            PH_POLL: begin
              if (reply_length < 8'd2) begin
                phase_next = PH_FAIL;
              end else if ((poll_status & busy_mask) != 16'd0) begin
                busy_polls_next = busy_polls_inc;
                if (busy_polls_inc >= busy_poll_limit) phase_next = PH_FAIL;
              end else if ((poll_status & error_mask) != 16'd0) begin
                if ((poll_status & nack_mask) != 16'd0) begin
                  nack_retries_next = nack_retries_inc;
                  phase_next = (nack_retries_inc >= nack_retry_limit) ? PH_FAIL : PH_ADDR;
                end else begin
                  phase_next = PH_FAIL;
                end
              end else begin
                phase_next = PH_DATA;
              end
            end
            PH_DATA: begin
              if (reply_length < 8'd4) begin
                phase_next = PH_FAIL;
              end else begin
                cache_hit         = 1'b1;
                pairs_done_next   = pairs_done_inc;
                nack_retries_next = '0;
                word_address_next = word_address + 16'd2;
                phase_next        = (pairs_done_inc >= pair_count) ? PH_DONE : PH_ADDR;
              end
            end
            default: phase_next = PH_FAIL;
          endcase
        end
      end
      sii_rd_pkg::MODE_CANCEL: begin
        if (phase != PH_DONE && phase != PH_FAIL) phase_next = PH_FAIL;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      word_address <= '0;
      pairs_done   <= '0;
      nack_retries <= '0;
      busy_polls   <= '0;
    end else if (accept) begin
      phase        <= phase_next;
      word_address <= word_address_next;
      pairs_done   <= pairs_done_next;
      nack_retries <= nack_retries_next;
      busy_polls   <= busy_polls_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      request_valid      <= 1'b0;
      request_is_write   <= 1'b0;
      request_register   <= sii_rd_pkg::REG_ADDRESS;
      request_payload    <= '0;
      request_bytes      <= 3'd0;
      request_station    <= '0;
      unique case (phase_next)
        PH_ADDR: begin
          request_valid    <= 1'b1;
          request_is_write <= 1'b1;
          request_register <= sii_rd_pkg::REG_ADDRESS;
          request_payload  <= word_address_next;
          request_bytes    <= 3'd2;
          request_station  <= 16'd0 - slave_position;
        end
        PH_CTL: begin
          request_valid    <= 1'b1;
          request_is_write <= 1'b1;
          request_register <= sii_rd_pkg::REG_CONTROL;
          request_payload  <= READ_COMMAND_CODE;
          request_bytes    <= 3'd2;
          request_station  <= 16'd0 - slave_position;
        end
        PH_POLL: begin
          request_valid    <= 1'b1;
          request_register <= sii_rd_pkg::REG_STATUS;
          request_bytes    <= 3'd2;
          request_station  <= 16'd0 - slave_position;
        end
        PH_DATA: begin
          request_valid    <= 1'b1;
          request_register <= sii_rd_pkg::REG_DATA;
          request_bytes    <= 3'd4;
          request_station  <= 16'd0 - slave_position;
        end
        default: ;
      endcase
      cache_valid        <= cache_hit;
      cache_word_address <= cache_hit ? word_address : 16'd0;
      cache_word_pair    <= cache_hit ? reply_data : 32'd0;
      if (phase_next == PH_DONE) begin
        sequence_status <= sii_rd_pkg::STATUS_DONE;
      end else if (phase_next == PH_FAIL) begin
        sequence_status <= sii_rd_pkg::STATUS_FAILED;
      end else begin
        sequence_status <= sii_rd_pkg::STATUS_BUSY;
      end
    end
  end

  // a request only goes out while the sequence is still running
  assert property (@(posedge clk) disable iff (rst)
    out_valid && request_valid |-> sequence_status == sii_rd_pkg::STATUS_BUSY)
    else $error("request issued with sequence finished");

  // a cached pair is followed by the next address write or by done
  assert property (@(posedge clk) disable iff (rst)
    out_valid && cache_valid |->
      sequence_status == sii_rd_pkg::STATUS_DONE ||
      (request_valid && request_is_write && request_register == sii_rd_pkg::REG_ADDRESS))
    else $error("cached pair not followed by address write or done");

  // a held result blocks the input side
  assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result held");

  // every result beat comes from an accepted input beat
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && !in_stall))
    else $error("result appeared without an input beat");

endmodule

// ===== dv/sii_rd_tb_pkg.sv =====
// scoreboard types and read-sequence tracker for the sii eeprom read sequencer bench
`timescale 1ns / 1ps

package sii_rd_tb_pkg;

  import sii_rd_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam logic [2:0] WORD_ACCESS_BYTES = 3'd2;
  localparam logic [2:0] PAIR_ACCESS_BYTES = 3'd4;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_ADDR, SEQ_CTL, SEQ_POLL, SEQ_DATA, SEQ_DONE, SEQ_FAIL
  } seq_phase_e;

  typedef struct packed {
    logic [1:0]  mode;
    logic        access_ok;
    logic [7:0]  reply_length;
    logic [31:0] reply_data;
  } reply_beat_t;

  typedef struct packed {
    logic        req_valid;
    logic        req_write;
    logic [1:0]  req_register;
    logic [15:0] req_payload;
    logic [2:0]  req_bytes;
    logic [15:0] req_station;
    logic        cache_valid;
    logic [15:0] cache_address;
    logic [31:0] cache_pair;
    logic [1:0]  status;
  } access_plan_t;

  class eeprom_read_tracker;
    logic [15:0] base_word;
    logic [15:0] pair_count;
    logic [15:0] slave_position;
    logic [15:0] busy_mask;
    logic [15:0] error_mask;
    logic [15:0] nack_mask;
    logic [15:0] busy_poll_limit;
    logic [7:0]  nack_retry_limit;

    seq_phase_e  phase;
    logic [15:0] word_address;
    logic [15:0] pairs_done;
    logic [15:0] busy_polls;
    logic [7:0]  nack_retries;

    access_plan_t pending_plans[$];
    int mismatches;

    function new();
      base_word = '0;
      pair_count = '0;
      slave_position = '0;
      busy_mask = BUSY_MASK_RESET;
      error_mask = ERROR_MASK_RESET;
      nack_mask = NACK_MASK_RESET;
      busy_poll_limit = BUSY_POLL_LIMIT_RESET;
      nack_retry_limit = NACK_RETRY_LIMIT_RESET;
      phase = SEQ_IDLE;
      word_address = '0;
      pairs_done = '0;
      busy_polls = '0;
      nack_retries = '0;
      mismatches = 0;
    endfunction

    function void set_register(logic [2:0] index, logic [15:0] value);
      case (index)
        CFG_BASE_WORD: base_word = value;
        CFG_PAIR_COUNT: pair_count = value;
        CFG_SLAVE_POSITION: slave_position = value;
        CFG_BUSY_MASK: busy_mask = value;
        CFG_ERROR_MASK: error_mask = value;
        CFG_NACK_MASK: nack_mask = value;
        CFG_BUSY_POLL_LIMIT: busy_poll_limit = value;
        default: nack_retry_limit = value[7:0];
      endcase
    endfunction

    function bit finished();
      return phase == SEQ_DONE || phase == SEQ_FAIL;
    endfunction

    function access_plan_t advance_sequence(reply_beat_t beat);
      access_plan_t plan;
      logic [15:0] st;
      plan = '0;
      st = beat.reply_data[15:0];
      case (beat.mode)
        MODE_START: begin
          word_address = base_word & WORD_ALIGN_MASK;
          pairs_done = '0;
          nack_retries = '0;
          busy_polls = '0;
          phase = (pair_count != 16'd0) ? SEQ_ADDR : SEQ_DONE;
        end
        MODE_COMPLETE: begin
          if (!beat.access_ok || phase == SEQ_IDLE || phase == SEQ_DONE || phase == SEQ_FAIL)
            phase = SEQ_FAIL;
          else if (phase == SEQ_ADDR)
            phase = SEQ_CTL;
          else if (phase == SEQ_CTL) begin
            busy_polls = '0;
            phase = SEQ_POLL;
          end else if (phase == SEQ_POLL) begin
            if (beat.reply_length < 8'(WORD_ACCESS_BYTES))
              phase = SEQ_FAIL;
            else if ((st & busy_mask) != 16'd0) begin
              busy_polls = busy_polls + 16'd1;
              if (busy_polls >= busy_poll_limit) phase = SEQ_FAIL;
            end else if ((st & error_mask) != 16'd0) begin
              if ((st & nack_mask) != 16'd0) begin
                nack_retries = nack_retries + 8'd1;
                phase = (nack_retries >= nack_retry_limit) ? SEQ_FAIL : SEQ_ADDR;
              end else begin
                phase = SEQ_FAIL;
              end
            end else begin
              phase = SEQ_DATA;
            end
          end else if (beat.reply_length < 8'(PAIR_ACCESS_BYTES)) begin
            phase = SEQ_FAIL;
          end else begin
            plan.cache_valid = 1'b1;
            plan.cache_address = word_address;
            plan.cache_pair = beat.reply_data;
            pairs_done = pairs_done + 16'd1;
            nack_retries = '0;
            word_address = word_address + 16'd2;
            phase = (pairs_done >= pair_count) ? SEQ_DONE : SEQ_ADDR;
          end
        end
        MODE_CANCEL: begin
          if (phase != SEQ_DONE && phase != SEQ_FAIL) phase = SEQ_FAIL;
        end
        default: ;
      endcase

      plan.status = STATUS_BUSY;
      case (phase)
        SEQ_ADDR: begin
          plan.req_valid = 1'b1;
          plan.req_write = 1'b1;
          plan.req_register = REG_ADDRESS;
          plan.req_payload = word_address;
          plan.req_bytes = WORD_ACCESS_BYTES;
        end
        SEQ_CTL: begin
          plan.req_valid = 1'b1;
          plan.req_write = 1'b1;
          plan.req_register = REG_CONTROL;
          plan.req_payload = 16'(READ_COMMAND_CODE_DEFAULT);
          plan.req_bytes = WORD_ACCESS_BYTES;
        end
        SEQ_POLL: begin
          plan.req_valid = 1'b1;
          plan.req_register = REG_STATUS;
          plan.req_bytes = WORD_ACCESS_BYTES;
        end
        SEQ_DATA: begin
          plan.req_valid = 1'b1;
          plan.req_register = REG_DATA;
          plan.req_bytes = PAIR_ACCESS_BYTES;
        end
        SEQ_DONE: plan.status = STATUS_DONE;
        SEQ_FAIL: plan.status = STATUS_FAILED;
        default: ;
      endcase
      if (plan.req_valid) plan.req_station = 16'd0 - slave_position;
      return plan;
    endfunction

    function void note_beat(reply_beat_t beat);
      pending_plans = {pending_plans, advance_sequence(beat)};
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want)
        report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
    endtask

    task check_outcome(access_plan_t got);
      access_plan_t want;
      if (pending_plans.size() == 0) begin
        report_mismatch("result beat with nothing expected");
        return;
      end
      want = pending_plans.pop_front();
      compare_field("request_valid", 32'(got.req_valid), 32'(want.req_valid));
      compare_field("request_is_write", 32'(got.req_write), 32'(want.req_write));
      compare_field("request_register", 32'(got.req_register), 32'(want.req_register));
      compare_field("request_payload", 32'(got.req_payload), 32'(want.req_payload));
      compare_field("request_bytes", 32'(got.req_bytes), 32'(want.req_bytes));
      compare_field("request_station", 32'(got.req_station), 32'(want.req_station));
      compare_field("cache_valid", 32'(got.cache_valid), 32'(want.cache_valid));
      compare_field("cache_word_address", 32'(got.cache_address), 32'(want.cache_address));
      compare_field("cache_word_pair", got.cache_pair, want.cache_pair);
      compare_field("sequence_status", 32'(got.status), 32'(want.status));
    endtask
  endclass

endpackage

// ===== dv/testbench.sv =====
// top-level bench for the sii eeprom read sequencer
`timescale 1ns / 1ps

module testbench;

  import sii_rd_pkg::*;
  import sii_rd_tb_pkg::*;

  localparam int ITEM_TARGET = 1900;
  localparam int RANDOM_PHASES = 8;
  localparam int PHASE_QUOTA = (ITEM_TARGET - 60) / (RANDOM_PHASES - 1);
  localparam int QUIET_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef enum int {POLL_BUSY, POLL_NACK, POLL_ERROR, POLL_CLEAR} poll_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_write = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_START;
  logic        access_ok = 1'b0;
  logic [7:0]  reply_length = '0;
  logic [31:0] reply_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic        request_valid;
  logic        request_is_write;
  logic [1:0]  request_register;
  logic [15:0] request_payload;
  logic [2:0]  request_bytes;
  logic [15:0] request_station;
  logic        cache_valid;
  logic [15:0] cache_word_address;
  logic [31:0] cache_word_pair;
  logic [1:0]  sequence_status;

  eeprom_read_tracker tracker = new();
  int items_sent = 0;
  int in_burst = 0;
  int out_burst = 0;
  int quiet_cycles = 0;

  sii_eeprom_read_sequencer_unit dut (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int draw_gap(ref int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 31) == 0) burst = $urandom_range(10, 60);
    return $urandom_range(0, 15);
  endfunction

  task automatic send_beat(input logic [1:0] m, input logic ok, input logic [7:0] len,
                           input logic [31:0] data);
    int gap;
    reply_beat_t beat;
    gap = draw_gap(in_burst);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    mode = m;
    access_ok = ok;
    reply_length = len;
    reply_data = data;
    in_valid = 1'b1;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    beat = '{m, ok, len, data};
    tracker.note_beat(beat);
    if (m != MODE_IGNORED) items_sent++;
  endtask

  task automatic send_reply(input logic [7:0] len, input logic [31:0] data);
    send_beat(MODE_COMPLETE, 1'b1, len, data);
  endtask

  task automatic write_register(input logic [2:0] index, input logic [15:0] value);
    @(negedge clk);
    cfg_write = 1'b1;
    cfg_index = index;
    cfg_data = value;
    @(negedge clk);
    cfg_write = 1'b0;
    tracker.set_register(index, value);
  endtask

  task automatic apply_settings(input logic [15:0] first_word, input logic [15:0] pairs,
                                input logic [15:0] position, input logic [15:0] busy,
                                input logic [15:0] error, input logic [15:0] nack,
                                input logic [15:0] poll_limit, input logic [15:0] retry_limit);
    write_register(CFG_BASE_WORD, first_word);
    write_register(CFG_PAIR_COUNT, pairs);
    write_register(CFG_SLAVE_POSITION, position);
    write_register(CFG_BUSY_MASK, busy);
    write_register(CFG_ERROR_MASK, error);
    write_register(CFG_NACK_MASK, nack);
    write_register(CFG_BUSY_POLL_LIMIT, poll_limit);
    write_register(CFG_NACK_RETRY_LIMIT, retry_limit);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (tracker.pending_plans.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic configure_phase(input int p);
    logic [15:0] busy;
    logic [15:0] error;
    logic [15:0] pairs;
    case (p)
      0: apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, BUSY_MASK_RESET, ERROR_MASK_RESET,
                        NACK_MASK_RESET, 16'hFFFF, 16'h00FF);
      1: apply_settings(16'h0000, 16'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000,
                        16'hFFFF, 16'h01FF);
      2: apply_settings(16'($urandom), 16'd3, 16'($urandom), 16'hFFFF, 16'hFFFF, 16'hFFFF,
                        16'd1, 16'd1);
      3: apply_settings(16'($urandom), 16'd0, 16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'd2, 16'd2);
      4: apply_settings(16'($urandom), 16'hFFFF, 16'($urandom), BUSY_MASK_RESET,
                        ERROR_MASK_RESET, NACK_MASK_RESET, 16'd0, 16'd0);
      default: begin
        busy = 16'd1 << $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0) busy = busy | 16'($urandom);
        error = 16'($urandom) & ~busy;
        pairs = ($urandom_range(0, 15) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
        apply_settings(16'($urandom), pairs, 16'($urandom), busy, error, error & 16'($urandom),
                       16'($urandom_range(1, 6)), 16'($urandom_range(1, 4)));
      end
    endcase
  endtask

  function automatic logic [31:0] status_word(input poll_kind_e kind);
    logic [15:0] noise;
    logic [15:0] st;
    noise = 16'($urandom);
    case (kind)
      POLL_BUSY: st = noise | tracker.busy_mask;
      POLL_NACK: st = (noise & ~tracker.busy_mask) | (tracker.error_mask & tracker.nack_mask);
      POLL_ERROR: st = (noise & ~tracker.busy_mask & ~tracker.nack_mask)
                       | (tracker.error_mask & ~tracker.nack_mask);
      default: st = noise & ~tracker.busy_mask & ~tracker.error_mask;
    endcase
    return {16'($urandom), st};
  endfunction

  function automatic logic [7:0] reply_size(input int needed);
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, needed - 1));
    return 8'($urandom_range(needed, 255));
  endfunction

  task automatic run_sequence();
    int attempts;
    int polls;
    int pick;
    poll_kind_e kind;
    send_beat(MODE_START, 1'($urandom), 8'($urandom), $urandom);
    attempts = 0;
    while (!tracker.finished() && attempts < 8) begin
      attempts++;
      if ($urandom_range(0, 19) == 0) begin
        send_beat(2'($urandom), 1'($urandom), 8'($urandom), $urandom);
        continue;
      end
      // address write, then read command
      send_reply(8'($urandom), $urandom);
      send_reply(8'($urandom), $urandom);
      polls = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 6) : $urandom_range(0, 2);
      repeat (polls)
        if (tracker.phase == SEQ_POLL) send_reply(reply_size(2), status_word(POLL_BUSY));
      pick = $urandom_range(0, 15);
      if (pick < 3) kind = POLL_NACK;
      else if (pick == 3) kind = POLL_ERROR;
      else kind = POLL_CLEAR;
      send_reply(reply_size(2), status_word(kind));
      if (tracker.phase == SEQ_DATA) send_reply(reply_size(4), $urandom);
    end
    if (!tracker.finished() && $urandom_range(0, 3) == 0)
      send_beat(MODE_CANCEL, 1'($urandom), 8'($urandom), $urandom);
  endtask

  // result side
  initial begin : result_sink
    int gap;
    access_plan_t got;
    forever begin
      gap = draw_gap(out_burst);
      @(negedge clk);
      if (gap > 0) begin
        out_stall = 1'b1;
        repeat (gap) @(negedge clk);
      end
      out_stall = 1'b0;
      @(posedge clk);
      while (out_valid !== 1'b1) @(posedge clk);
      got = '{request_valid, request_is_write, request_register, request_payload,
              request_bytes, request_station, cache_valid, cache_word_address,
              cache_word_pair, sequence_status};
      tracker.check_outcome(got);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    int quota;
    repeat (11) @(negedge clk);
    rst = 1'b0;

    apply_settings(16'h0003, 16'd2, 16'd1, BUSY_MASK_RESET, ERROR_MASK_RESET,
                   NACK_MASK_RESET, BUSY_POLL_LIMIT_RESET, 16'(NACK_RETRY_LIMIT_RESET));
    send_reply(8'd4, 32'h0);
    send_beat(MODE_CANCEL, 1'b0, 8'd0, 32'h0);
    send_beat(MODE_IGNORED, 1'b1, 8'hFF, 32'hFFFF_FFFF);
    send_beat(MODE_START, 1'b0, 8'd0, 32'h0);
    send_reply(8'd2, 32'h0);
    send_beat(MODE_IGNORED, 1'b0, 8'd0, 32'h0);
    send_reply(8'd2, 32'h0);
    send_reply(8'd2, 32'h0000_8000);
    send_reply(8'd2, 32'h0000_2800);
    send_reply(8'd2, 32'h0);
    send_reply(8'd2, 32'h0);
    send_reply(8'hFF, 32'hFFFF_0000);
    send_reply(8'd4, 32'hFFFF_FFFF);
    send_reply(8'd2, 32'h0);
    send_reply(8'd2, 32'h0);
    send_reply(8'd2, 32'h0);
    send_reply(8'd4, 32'h1234_5678);
    send_reply(8'd4, 32'h0);
    send_beat(MODE_START, 1'b1, 8'd0, 32'h0);
    send_beat(MODE_COMPLETE, 1'b0, 8'd4, 32'h0);
    send_beat(MODE_START, 1'b1, 8'd0, 32'h0);
    send_reply(8'd2, 32'h0);
    send_reply(8'd2, 32'h0);
    send_reply(8'd2, 32'h0000_1000);
    send_beat(MODE_START, 1'b1, 8'd0, 32'h0);
    send_beat(MODE_CANCEL, 1'b1, 8'd0, 32'h0);

    // an empty run finishes at once
    wait_drained();
    write_register(CFG_PAIR_COUNT, 16'd0);
    send_beat(MODE_START, 1'b0, 8'd0, 32'h0);
    send_beat(MODE_CANCEL, 1'b0, 8'd0, 32'h0);
    send_reply(8'd4, 32'h0);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_drained();
      configure_phase(p);
      quota = items_sent + ((p == 3) ? 20 : PHASE_QUOTA);
      while (items_sent < quota) run_sequence();
    end

    wait_drained();
    if (tracker.mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
sv/sii_rd_pkg.sv
sv/sii_eeprom_read_sequencer_unit.sv
dv/sii_rd_tb_pkg.sv
dv/testbench.sv
